@@ rtl/dbc_pkg.sv @@
// shared constants, payload structs and cell/divider status types for box clustering
`default_nettype none

package dbc_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int COORD_BITS   = 11;
    localparam int COUNT_BITS   = 8;

    // fixed field widths of the register and the result beat
    localparam int RADIUS_W   = 8;
    localparam int MEMBER_W   = 8;
    localparam int CLUSTERS_W = 5;

    // doubled center 2x + w and the per-cluster sums
    localparam int CX2_W  = COORD_BITS + 2;
    localparam int SUM2_W = CX2_W + COUNT_BITS;
    localparam int SUMW_W = COORD_BITS + COUNT_BITS;

    // match limit 2*n*r and the width both sides are compared at
    localparam int LIM_W = COUNT_BITS + RADIUS_W + 1;
    localparam int CMP_W = (SUM2_W > LIM_W) ? SUM2_W : LIM_W;

    localparam int USED_W = $clog2(MAX_CLUSTERS + 1);
    localparam int CIDX_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;

    localparam int DIV_LANES = 4;
    localparam int DIV_CNT_W = $clog2(SUM2_W + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};
    localparam logic [RADIUS_W-1:0]   RADIUS_RESET = RADIUS_W'(3);

    typedef struct packed {
        logic [COORD_BITS-1:0] rect_x;
        logic [COORD_BITS-1:0] rect_y;
        logic [COORD_BITS-1:0] rect_width;
        logic [COORD_BITS-1:0] rect_height;
        logic                  last_item;
    } rect_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] box_x;
        logic [COORD_BITS-1:0] box_y;
        logic [COORD_BITS-1:0] box_width;
        logic [COORD_BITS-1:0] box_height;
        logic [MEMBER_W-1:0]   member_count;
        logic [CLUSTERS_W-1:0] clusters_used;
        logic                  overflow;
    } box_t;

    // rectangle as seen by the cells
    typedef struct packed {
        logic [CX2_W-1:0]      cx2;
        logic [CX2_W-1:0]      cy2;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } item_t;

    // best cluster so far, handed down the chain during the decision scan
    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [SUM2_W-1:0]     sx;
        logic [SUM2_W-1:0]     sy;
        logic [SUMW_W-1:0]     sw;
        logic [SUMW_W-1:0]     sh;
    } best_t;

    typedef struct packed {
        logic done;
        logic opened;
        logic dropped;
    } srch_evt_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef logic [DIV_LANES-1:0][SUM2_W-1:0] div_word_t;

endpackage

`default_nettype wire

@@ rtl/dbc_cell.sv @@
// one cluster cell: holds sums and count, tests the passing rectangle, joins the best scan
`default_nettype none

module dbc_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dbc_pkg::CIDX_W-1:0]   idx,
    input  logic [dbc_pkg::USED_W-1:0]   used,
    input  logic [dbc_pkg::RADIUS_W-1:0] radius,
    input  dbc_pkg::item_t               item,
    input  logic                         srch_tok_in,
    output logic                         srch_tok_out,
    output dbc_pkg::srch_evt_t           evt,
    input  logic                         scan_tok_in,
    input  dbc_pkg::best_t               best_in,
    output logic                         scan_tok_out,
    output dbc_pkg::best_t               best_out
);

    import dbc_pkg::*;

    logic [SUM2_W-1:0]     sx_reg, sx_next;
    logic [SUM2_W-1:0]     sy_reg, sy_next;
    logic [SUMW_W-1:0]     sw_reg, sw_next;
    logic [SUMW_W-1:0]     sh_reg, sh_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  srch_tok_reg, srch_tok_next;
    logic                  scan_tok_reg, scan_tok_next;
    best_t                 best_reg, best_next;

    logic                          in_use;
    logic [COUNT_BITS+RADIUS_W-1:0] n_r;
    logic [LIM_W-1:0]              lim;
    logic                          hit;
    logic                          take;

    // |sum - n*c2| < lim, all exact
    function automatic logic axis_close(
        input logic [SUM2_W-1:0]     sum,
        input logic [COUNT_BITS-1:0] n,
        input logic [CX2_W-1:0]      c2,
        input logic [LIM_W-1:0]      limit
    );
        logic [SUM2_W-1:0]        prod;
        logic signed [SUM2_W:0]   diff;
        logic [SUM2_W-1:0]        mag;
        prod = {{CX2_W{1'b0}}, n} * {{COUNT_BITS{1'b0}}, c2};
        diff = $signed({1'b0, sum}) - $signed({1'b0, prod});
        mag  = diff[SUM2_W] ? SUM2_W'(-diff) : diff[SUM2_W-1:0];
        return CMP_W'(mag) < CMP_W'(limit);
    endfunction

    assign in_use = USED_W'(idx) < used;
    assign n_r    = {{RADIUS_W{1'b0}}, cnt_reg} * {{COUNT_BITS{1'b0}}, radius};
    assign lim    = {n_r, 1'b0};
    assign hit    = axis_close(sx_reg, cnt_reg, item.cx2, lim)
                 && axis_close(sy_reg, cnt_reg, item.cy2, lim);
    assign take   = in_use && (cnt_reg > best_in.count);

    always_comb
    begin
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        sw_next       = sw_reg;
        sh_next       = sh_reg;
        cnt_next      = cnt_reg;
        srch_tok_next = 1'b0;
        evt           = '0;

        if (srch_tok_in)
        begin
            if (!in_use)
            begin
                // first free cell opens a new cluster
                sx_next    = SUM2_W'(item.cx2);
                sy_next    = SUM2_W'(item.cy2);
                sw_next    = SUMW_W'(item.w);
                sh_next    = SUMW_W'(item.h);
                cnt_next   = COUNT_BITS'(1);
                evt.done   = 1'b1;
                evt.opened = 1'b1;
            end
            else if (hit)
            begin
                evt.done = 1'b1;
                if (cnt_reg == COUNT_MAX)
                begin
                    evt.dropped = 1'b1;
                end
                else
                begin
                    sx_next  = sx_reg + SUM2_W'(item.cx2);
                    sy_next  = sy_reg + SUM2_W'(item.cy2);
                    sw_next  = sw_reg + SUMW_W'(item.w);
                    sh_next  = sh_reg + SUMW_W'(item.h);
                    cnt_next = cnt_reg + COUNT_BITS'(1);
                end
            end
            else
            begin
                srch_tok_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        best_next     = best_reg;
        scan_tok_next = scan_tok_in;
        if (scan_tok_in)
        begin
            // strictly larger only, so an earlier cluster keeps a tie
            if (take)
            begin
                best_next.count = cnt_reg;
                best_next.sx    = sx_reg;
                best_next.sy    = sy_reg;
                best_next.sw    = sw_reg;
                best_next.sh    = sh_reg;
            end
            else
            begin
                best_next = best_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_tok_reg <= 1'b0;
            scan_tok_reg <= 1'b0;
        end
        else
        begin
            srch_tok_reg <= srch_tok_next;
            scan_tok_reg <= scan_tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        sw_reg   <= sw_next;
        sh_reg   <= sh_next;
        cnt_reg  <= cnt_next;
        best_reg <= best_next;
    end

    assign srch_tok_out = srch_tok_reg;
    assign scan_tok_out = scan_tok_reg;
    assign best_out     = best_reg;

endmodule

`default_nettype wire

@@ rtl/dbc_div.sv @@
// four-lane restoring divider sharing one divisor, one quotient bit per cycle
`default_nettype none

module dbc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  dbc_pkg::div_word_t             dividend,
    input  logic [dbc_pkg::COUNT_BITS-1:0] divisor,
    output dbc_pkg::div_word_t             quotient,
    output dbc_pkg::div_stat_t             stat
);

    import dbc_pkg::*;

    div_word_t                             q_reg, q_next;
    logic [DIV_LANES-1:0][COUNT_BITS-1:0]  rem_reg, rem_next;
    logic [COUNT_BITS-1:0]                 d_reg, d_next;
    logic [DIV_CNT_W-1:0]                  cnt_reg, cnt_next;
    logic                                  busy_reg, busy_next;
    logic                                  done_reg, done_next;

    logic [DIV_LANES-1:0][COUNT_BITS:0]    shifted;
    logic [DIV_LANES-1:0]                  ge;

    always_comb
    begin
        for (int l = 0; l < DIV_LANES; l++)
        begin
            shifted[l] = {rem_reg[l], q_reg[l][SUM2_W-1]};
            ge[l]      = shifted[l] >= {1'b0, d_reg};
        end
    end

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;

        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
            cnt_next  = DIV_CNT_W'(SUM2_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            for (int l = 0; l < DIV_LANES; l++)
            begin
                rem_next[l] = ge[l] ? COUNT_BITS'(shifted[l] - {1'b0, d_reg})
                                    : shifted[l][COUNT_BITS-1:0];
                q_next[l]   = {q_reg[l][SUM2_W-2:0], ge[l]};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

@@ rtl/detection_box_clustering_core.sv @@
// top level: rectangle intake, cluster cell chain, decision scan, mean divider, result register
//
//  channel   signals                         handshake
//  --------  ------------------------------  -----------------------------
//  config    cfg_wen, cfg_wdata              write on cfg_wen, no wait
//  rect      rect_valid, rect_ready, rect    beat on valid & ready
//  box       box_valid, box_ready, box       beat on valid & ready
//
// a rectangle walks the cell chain one cell per cycle; the next beat is taken only once it has
// joined or opened a cell or been dropped on a full table, and a last rectangle is then
// followed by a decision scan down the chain and a division of the best cluster's sums
// the result register lets the next set start while a box beat waits on box_ready; a second
// finished box holds rect_ready low until that beat goes
// reset empties the table and sets match_radius to 3; no clearing pass is needed
`default_nettype none

module detection_box_clustering_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [dbc_pkg::RADIUS_W-1:0] cfg_wdata,
    input  logic                         rect_valid,
    output logic                         rect_ready,
    input  dbc_pkg::rect_t               rect,
    output logic                         box_valid,
    input  logic                         box_ready,
    output dbc_pkg::box_t                box
);

    import dbc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SEARCH = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_DIV    = 4'b1000
    } state_t;

    localparam int LANE_SX = 0;
    localparam int LANE_SY = 1;
    localparam int LANE_SW = 2;
    localparam int LANE_SH = 3;

    state_t                state_reg, state_next;
    logic [RADIUS_W-1:0]   radius_reg, radius_next;
    item_t                 item_reg, item_next;
    logic                  last_reg, last_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic                  drop_reg, drop_next;
    logic                  srch_go_reg, srch_go_next;
    logic                  scan_go_reg, scan_go_next;
    logic [USED_W-1:0]     res_used_reg, res_used_next;
    logic                  res_drop_reg, res_drop_next;
    logic [COUNT_BITS-1:0] res_n_reg, res_n_next;
    box_t                  box_reg, box_next;
    logic                  box_valid_reg, box_valid_next;

    logic [MAX_CLUSTERS:0]   srch_chain;
    logic [MAX_CLUSTERS:0]   scan_chain;
    best_t                   best_chain [MAX_CLUSTERS+1];
    srch_evt_t               evt [MAX_CLUSTERS];
    srch_evt_t               evt_any;

    logic       accept;
    logic       srch_done;
    logic       div_start;
    logic       box_load;
    div_word_t  dividend;
    div_word_t  quotient;
    div_stat_t  div_stat;
    best_t      best_tail;

    logic [SUM2_W-1:0] mean_w;
    logic [SUM2_W-1:0] mean_h;
    logic [SUM2_W-1:0] corner_x;
    logic [SUM2_W-1:0] corner_y;

    assign srch_chain[0] = srch_go_reg;
    assign scan_chain[0] = scan_go_reg;
    assign best_chain[0] = '0;
    assign best_tail     = best_chain[MAX_CLUSTERS];

    for (genvar i = 0; i < MAX_CLUSTERS; i++)
    begin : g_cell
        dbc_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .idx          (CIDX_W'(i)),
            .used         (used_reg),
            .radius       (radius_reg),
            .item         (item_reg),
            .srch_tok_in  (srch_chain[i]),
            .srch_tok_out (srch_chain[i+1]),
            .evt          (evt[i]),
            .scan_tok_in  (scan_chain[i]),
            .best_in      (best_chain[i]),
            .scan_tok_out (scan_chain[i+1]),
            .best_out     (best_chain[i+1])
        );
    end

    always_comb
    begin
        evt_any = '0;
        for (int i = 0; i < MAX_CLUSTERS; i++)
        begin
            evt_any = evt_any | evt[i];
        end
    end

    // token fell off the end: no match with a full table
    assign srch_done = evt_any.done || srch_chain[MAX_CLUSTERS];

    assign dividend[LANE_SX] = best_tail.sx;
    assign dividend[LANE_SY] = best_tail.sy;
    assign dividend[LANE_SW] = SUM2_W'(best_tail.sw);
    assign dividend[LANE_SH] = SUM2_W'(best_tail.sh);

    dbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (best_tail.count),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // floor(s/2n) is floor(floor(s/n)/2)
    assign mean_w   = quotient[LANE_SW];
    assign mean_h   = quotient[LANE_SH];
    assign corner_x = (quotient[LANE_SX] >> 1) - (mean_w >> 1);
    assign corner_y = (quotient[LANE_SY] >> 1) - (mean_h >> 1);

    assign rect_ready = (state_reg == ST_IDLE);
    assign accept     = rect_valid && rect_ready;

    always_comb
    begin
        state_next     = state_reg;
        radius_next    = radius_reg;
        item_next      = item_reg;
        last_next      = last_reg;
        used_next      = used_reg;
        drop_next      = drop_reg;
        srch_go_next   = 1'b0;
        scan_go_next   = 1'b0;
        res_used_next  = res_used_reg;
        res_drop_next  = res_drop_reg;
        res_n_next     = res_n_reg;
        box_next       = box_reg;
        div_start      = 1'b0;
        box_load       = 1'b0;

        if (cfg_wen)
        begin
            radius_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next.cx2 = {1'b0, rect.rect_x, 1'b0} + CX2_W'(rect.rect_width);
                    item_next.cy2 = {1'b0, rect.rect_y, 1'b0} + CX2_W'(rect.rect_height);
                    item_next.w   = rect.rect_width;
                    item_next.h   = rect.rect_height;
                    last_next     = rect.last_item;
                    srch_go_next  = 1'b1;
                    state_next    = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (srch_done)
                begin
                    if (evt_any.opened)
                    begin
                        used_next = used_reg + USED_W'(1);
                    end
                    if (evt_any.dropped || srch_chain[MAX_CLUSTERS])
                    begin
                        drop_next = 1'b1;
                    end
                    if (last_reg)
                    begin
                        scan_go_next = 1'b1;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_chain[MAX_CLUSTERS])
                begin
                    used_next = '0;
                    drop_next = 1'b0;
                    if (used_reg != '0)
                    begin
                        res_used_next = used_reg;
                        res_drop_next = drop_reg;
                        res_n_next    = best_tail.count;
                        div_start     = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done && (!box_valid_reg || box_ready))
                begin
                    box_load = 1'b1;
                    box_next.box_x         = COORD_BITS'(corner_x);
                    box_next.box_y         = COORD_BITS'(corner_y);
                    box_next.box_width     = COORD_BITS'(mean_w);
                    box_next.box_height    = COORD_BITS'(mean_h);
                    box_next.member_count  = MEMBER_W'(res_n_reg);
                    box_next.clusters_used = CLUSTERS_W'(res_used_reg);
                    box_next.overflow      = res_drop_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (box_load)
        begin
            box_valid_next = 1'b1;
        end
        else if (box_ready)
        begin
            box_valid_next = 1'b0;
        end
        else
        begin
            box_valid_next = box_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radius_reg    <= RADIUS_RESET;
            used_reg      <= '0;
            drop_reg      <= 1'b0;
            srch_go_reg   <= 1'b0;
            scan_go_reg   <= 1'b0;
            box_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radius_reg    <= radius_next;
            used_reg      <= used_next;
            drop_reg      <= drop_next;
            srch_go_reg   <= srch_go_next;
            scan_go_reg   <= scan_go_next;
            box_valid_reg <= box_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        last_reg     <= last_next;
        res_used_reg <= res_used_next;
        res_drop_reg <= res_drop_next;
        res_n_reg    <= res_n_next;
        box_reg      <= box_next;
    end

    assign box_valid = box_valid_reg;
    assign box       = box_reg;

    // one rectangle or one decision in flight anywhere in the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({srch_chain, scan_chain}))
        else $error("more than one token in the cell chain");

    a_evt_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        evt_any.done |-> (state_reg == ST_SEARCH))
        else $error("cell event outside a search");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(MAX_CLUSTERS))
        else $error("cluster count beyond table size");

endmodule

`default_nettype wire

@@ dv/box_cluster_checker.sv @@
// checker: predicts the clustered box of every rectangle set and compares it with the box beats
module box_cluster_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wen,
    input  logic [dbc_pkg::RADIUS_W-1:0] cfg_wdata,
    input  logic                         rect_valid,
    input  logic                         rect_ready,
    input  dbc_pkg::rect_t               rect,
    input  logic                         box_valid,
    input  logic                         box_ready,
    input  dbc_pkg::box_t                box,
    output int                           mismatches,
    output int                           boxes_pending
);
    import dbc_pkg::*;

    localparam int PRINT_CAP = 40;

    logic [RADIUS_W-1:0]   radius;
    logic [SUM2_W-1:0]     acc_cx2 [MAX_CLUSTERS];
    logic [SUM2_W-1:0]     acc_cy2 [MAX_CLUSTERS];
    logic [SUMW_W-1:0]     acc_w   [MAX_CLUSTERS];
    logic [SUMW_W-1:0]     acc_h   [MAX_CLUSTERS];
    logic [COUNT_BITS-1:0] members [MAX_CLUSTERS];
    logic [USED_W-1:0]     n_open;
    logic                  lost_rect;
    box_t                  expected_boxes [$];

    task automatic report(input string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t box check: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // |mean center - center| < radius, scaled by 2n to stay in integers
    function automatic bit near_center(input logic [SUM2_W-1:0] total,
                                       input logic [COUNT_BITS-1:0] n,
                                       input logic [CX2_W-1:0] c2);
        longint diff;
        diff = longint'(total) - longint'(n) * longint'(c2);
        if (diff < 0)
            diff = -diff;
        return diff < 2 * longint'(n) * longint'(radius);
    endfunction

    task automatic absorb_rect(input rect_t r);
        logic [CX2_W-1:0] cx2;
        logic [CX2_W-1:0] cy2;
        int hit;
        int best;
        int i;
        longint nn;
        box_t b;
        cx2 = CX2_W'(2 * int'(r.rect_x) + int'(r.rect_width));
        cy2 = CX2_W'(2 * int'(r.rect_y) + int'(r.rect_height));
        hit = -1;
        for (i = 0; i < n_open; i++)
        begin
            if (hit < 0 && near_center(acc_cx2[i], members[i], cx2)
                        && near_center(acc_cy2[i], members[i], cy2))
                hit = i;
        end
        if (hit >= 0)
        begin
            // a full cluster swallows the rectangle without passing it on
            if (members[hit] == COUNT_MAX)
                lost_rect = 1'b1;
            else
            begin
                acc_cx2[hit] = acc_cx2[hit] + cx2;
                acc_cy2[hit] = acc_cy2[hit] + cy2;
                acc_w[hit]   = acc_w[hit] + r.rect_width;
                acc_h[hit]   = acc_h[hit] + r.rect_height;
                members[hit] = members[hit] + 1'b1;
            end
        end
        else if (n_open == MAX_CLUSTERS)
            lost_rect = 1'b1;
        else
        begin
            acc_cx2[n_open] = SUM2_W'(cx2);
            acc_cy2[n_open] = SUM2_W'(cy2);
            acc_w[n_open]   = SUMW_W'(r.rect_width);
            acc_h[n_open]   = SUMW_W'(r.rect_height);
            members[n_open] = COUNT_BITS'(1);
            n_open = n_open + 1'b1;
        end

        if (r.last_item)
        begin
            if (n_open != 0)
            begin
                // earliest cluster keeps a tie
                best = 0;
                for (i = 1; i < n_open; i++)
                begin
                    if (members[i] > members[best])
                        best = i;
                end
                nn = longint'(members[best]);
                b.box_width     = COORD_BITS'(longint'(acc_w[best]) / nn);
                b.box_height    = COORD_BITS'(longint'(acc_h[best]) / nn);
                b.box_x         = COORD_BITS'(longint'(acc_cx2[best]) / (2 * nn)
                                              - longint'(acc_w[best]) / (2 * nn));
                b.box_y         = COORD_BITS'(longint'(acc_cy2[best]) / (2 * nn)
                                              - longint'(acc_h[best]) / (2 * nn));
                b.member_count  = MEMBER_W'(nn);
                b.clusters_used = CLUSTERS_W'(n_open);
                b.overflow      = lost_rect;
                expected_boxes.insert(expected_boxes.size(), b);
            end
            n_open    = '0;
            lost_rect = 1'b0;
        end
    endtask

    task automatic check_box(input box_t got);
        box_t want;
        if (expected_boxes.size() == 0)
        begin
            report("box beat with no set pending");
            return;
        end
        want = expected_boxes.pop_front();
        compare_field("box_x", 16'(got.box_x), 16'(want.box_x));
        compare_field("box_y", 16'(got.box_y), 16'(want.box_y));
        compare_field("box_width", 16'(got.box_width), 16'(want.box_width));
        compare_field("box_height", 16'(got.box_height), 16'(want.box_height));
        compare_field("member_count", 16'(got.member_count), 16'(want.member_count));
        compare_field("clusters_used", 16'(got.clusters_used), 16'(want.clusters_used));
        compare_field("overflow", 16'(got.overflow), 16'(want.overflow));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius     = RADIUS_RESET;
            n_open     = '0;
            lost_rect  = 1'b0;
            mismatches = 0;
            expected_boxes.delete();
            boxes_pending <= 0;
        end
        else
        begin
            if (cfg_wen)
                radius = cfg_wdata;
            // box first, so a box never meets the expectation of the same edge
            if (box_valid && box_ready)
                check_box(box);
            if (rect_valid && rect_ready)
                absorb_rect(rect);
            boxes_pending <= expected_boxes.size();
        end
    end

endmodule

@@ dv/tb.sv @@
// testbench top: rectangle stimulus, box sink with stalls, radius phases and the verdict
module tb;
    import dbc_pkg::*;

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam int SETTLE    = 64;
    localparam int LONG_HOLD = 600;
    localparam int PHASE_LEN = 140;

    typedef enum int {SET_CLUSTERED, SET_SPREAD, SET_NOISE, SET_SATURATE} set_kind_t;
    typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_STALL} sink_mode_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_wen    = 1'b0;
    logic [RADIUS_W-1:0] cfg_wdata  = '0;
    logic                rect_valid = 1'b0;
    rect_t               rect       = '0;
    logic                box_ready  = 1'b0;
    logic                rect_ready;
    logic                box_valid;
    box_t                box;
    int                  mismatches;
    int                  boxes_pending;
    int                  items_sent = 0;
    int                  radius_now = 3;

    detection_box_clustering_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_wdata  (cfg_wdata),
        .rect_valid (rect_valid),
        .rect_ready (rect_ready),
        .rect       (rect),
        .box_valid  (box_valid),
        .box_ready  (box_ready),
        .box        (box)
    );

    box_cluster_checker CHK (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .rect_valid    (rect_valid),
        .rect_ready    (rect_ready),
        .rect          (rect),
        .box_valid     (box_valid),
        .box_ready     (box_ready),
        .box           (box),
        .mismatches    (mismatches),
        .boxes_pending (boxes_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rect_t mk(input int x, input int y, input int w, input int h,
                                 input bit last);
        rect_t r;
        r.rect_x      = COORD_BITS'(x);
        r.rect_y      = COORD_BITS'(y);
        r.rect_width  = COORD_BITS'(w);
        r.rect_height = COORD_BITS'(h);
        r.last_item   = last;
        return r;
    endfunction

    function automatic rect_t any_rect();
        return mk($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(1, COORD_MAX), $urandom_range(1, COORD_MAX), 1'b0);
    endfunction

    function automatic int nudge(input logic [COORD_BITS-1:0] v, input int jit, input int lo);
        int t;
        t = int'(v) + int'($urandom_range(0, 2 * jit)) - jit;
        if (t < lo)
            t = lo;
        if (t > COORD_MAX)
            t = COORD_MAX;
        return t;
    endfunction

    function automatic rect_t jitter_rect(input rect_t a, input int jit);
        return mk(nudge(a.rect_x, jit, 0), nudge(a.rect_y, jit, 0),
                  nudge(a.rect_width, jit, 1), nudge(a.rect_height, jit, 1), 1'b0);
    endfunction

    // mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    task automatic send_rect(input rect_t r);
        rect       <= r;
        rect_valid <= 1'b1;
        @(posedge clk);
        while (!rect_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic idle_rect(input int n);
        if (n > 0)
        begin
            rect_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_idle(input int extra);
        rect_valid <= 1'b0;
        @(posedge clk);
        while (boxes_pending != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_radius(input int v);
        cfg_wen    <= 1'b1;
        cfg_wdata  <= RADIUS_W'(v);
        radius_now = v;
        @(posedge clk);
        cfg_wen    <= 1'b0;
    endtask

    task automatic send_set(input set_kind_t kind);
        rect_t anchors [20];
        rect_t r;
        int n_anchor;
        int n_items;
        int jit;
        int i;
        bit noisy;
        bit tight;
        tight = ($urandom_range(0, 2) == 0);
        jit = (radius_now < 4) ? 3 : ((radius_now > 40) ? 40 : radius_now + 2);
        case (kind)
            SET_SPREAD:
            begin
                n_anchor = $urandom_range(14, 20);
                n_items  = $urandom_range(17, 30);
            end
            SET_NOISE:
            begin
                n_anchor = 1;
                n_items  = $urandom_range(1, 6);
            end
            SET_SATURATE:
            begin
                n_anchor = 1;
                n_items  = $urandom_range(259, 262);
                jit      = 20;
            end
            default:
            begin
                n_anchor = $urandom_range(1, 5);
                n_items  = $urandom_range(1, 14);
            end
        endcase
        for (i = 0; i < n_anchor; i++)
            anchors[i] = any_rect();
        for (i = 0; i < n_items; i++)
        begin
            if (kind == SET_NOISE)
                noisy = 1'b1;
            else if (kind == SET_SATURATE)
                noisy = (i >= n_items - 3);
            else
                noisy = ($urandom_range(0, 7) == 0);
            r = noisy ? any_rect()
                      : jitter_rect(anchors[$urandom_range(0, n_anchor - 1)], jit);
            r.last_item = (i == n_items - 1);
            send_rect(r);
            if (!tight)
                idle_rect(pick_gap());
        end
    endtask

    task automatic directed_sets();
        int i;
        send_rect(mk(0, 0, 1, 1, 1'b1));
        send_rect(mk(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
        // tie between two single clusters
        send_rect(mk(100, 100, 10, 10, 1'b0));
        send_rect(mk(600, 600, 20, 20, 1'b1));
        // later cluster grows larger
        send_rect(mk(100, 100, 10, 10, 1'b0));
        send_rect(mk(900, 300, 30, 40, 1'b0));
        send_rect(mk(901, 301, 31, 39, 1'b1));
        // center offset equal to the radius stays apart
        send_rect(mk(100, 100, 10, 10, 1'b0));
        send_rect(mk(103, 100, 10, 10, 1'b1));
        // half-pixel center just inside the radius joins
        send_rect(mk(100, 100, 10, 10, 1'b0));
        send_rect(mk(102, 100, 11, 10, 1'b1));
        // seventeen far-apart rectangles overrun the table
        for (i = 0; i <= MAX_CLUSTERS; i++)
            send_rect(mk(i * 120, COORD_MAX - i * 120, 1 + i * 100, COORD_MAX - i * 100,
                         i == MAX_CLUSTERS));
    endtask

    initial
    begin : stimulus
        int radius_plan [8];
        int phase;
        int start;
        int r;
        radius_plan = '{255, 1, 0, 8, 0, 0, 128, 3};
        radius_plan[4] = $urandom_range(2, 20);
        radius_plan[5] = $urandom_range(21, 254);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_sets();
        for (phase = 0; phase < 8; phase++)
        begin
            wait_idle(SETTLE);
            write_radius(radius_plan[phase]);
            if (radius_plan[phase] == 255)
                send_set(SET_SATURATE);
            start = items_sent;
            while (items_sent - start < PHASE_LEN)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_set(SET_CLUSTERED);
                else if (r < 82)
                    send_set(SET_SPREAD);
                else
                    send_set(SET_NOISE);
                if ($urandom_range(0, 9) == 0)
                    wait_idle(0);
            end
        end
        wait_idle(SETTLE);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : box_sink
        sink_mode_t mode;
        int run_left;
        int hold_left;
        int sunk;
        int next_hold;
        mode      = SINK_OPEN;
        run_left  = 0;
        hold_left = 0;
        sunk      = 0;
        next_hold = 6;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (box_valid && box_ready)
                sunk++;
            // long hold-off so the result register fills and the intake backs up
            if (hold_left == 0 && sunk >= next_hold)
            begin
                hold_left = LONG_HOLD;
                next_hold = next_hold + 120;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                box_ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode = sink_mode_t'($urandom_range(0, 2));
                    if (mode == SINK_STALL)
                        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100)
                                                               : $urandom_range(1, 4);
                    else
                        run_left = $urandom_range(5, 60);
                end
                run_left--;
                case (mode)
                    SINK_OPEN:   box_ready <= 1'b1;
                    SINK_CHOPPY: box_ready <= 1'($urandom_range(0, 1));
                    default:     box_ready <= 1'b0;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
